/* rtl/core/bsdf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bsdf_pkg
// Constants for the advertisement service-data finder.
// ----------------------------------------------------------------------------
package bsdf_pkg;

  // longest advertisement the walker honours (frame length is clamped to it)
  localparam logic [8:0] MAX_ADV_LEN   = 9'd255;

  // service-data AD type and the identifier bytes that follow it
  localparam logic [7:0] AD_TYPE_SVC16 = 8'h16;
  localparam logic [7:0] UUID_LO       = 8'hFA;
  localparam logic [7:0] UUID_HI       = 8'hFF;
  localparam logic [7:0] ODID_APP_ID   = 8'h0D;

  // shortest structure length accepted as carrying the identifier
  localparam logic [7:0] MIN_SVC_LEN   = 8'd5;
  // shortest frame that can report a match
  localparam logic [7:0] MIN_FRAME_LEN = 8'd6;
  // message bytes start this far after the structure's length byte
  localparam logic [7:0] MSG_OFFSET    = 8'd6;

endpackage : bsdf_pkg
`default_nettype wire

/* rtl/core/ble_astm_service_data_finder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ble_astm_service_data_finder
// Walks the AD structures of a BLE advertisement, one byte per transfer, and
// reports on the last byte the first service-data structure carrying the
// drone ID identifier.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                         | result
//  --------+-----------+-----------------------------------------------+--------
//  in_     | input     | valid, stall, adv_byte, adv_len, last_byte    | -
//  out_    | output    | valid, stall, found, payload_offset, length   | 1/frame
//
//  One byte is taken every cycle unless a last byte is stalled; the walk state is updated by the short
//  compare/add logic between the input and the state registers.
//  A result is registered and shows in the cycle after the last byte of a frame is taken.
//  Bytes that are not last are taken even while a result waits; a last byte
//  stalls only while the result register is full and stalled.
//  rst_n (synchronous, active low) clears the walk state and the result valid.
// ----------------------------------------------------------------------------
module ble_astm_service_data_finder
  import bsdf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_adv_byte,
  input  wire logic [7:0] in_adv_len,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_found,
  output logic [7:0]      out_payload_offset,
  output logic [7:0]      out_payload_length
);

  typedef enum logic [2:0] {
    WAIT_LEN,
    CHK_TYPE,
    CHK_UUID_LO,
    CHK_UUID_HI,
    CHK_APP
  } stage_t;

  stage_t     stage_r, stage_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [8:0] next_start_r, next_start_nxt;
  logic [7:0] struct_len_r, struct_len_nxt;
  logic       stopped_r, stopped_nxt;
  logic       found_r, found_nxt;
  logic [7:0] match_off_r, match_off_nxt;
  logic [7:0] match_len_r, match_len_nxt;

  logic       out_valid_r;
  logic       out_found_r;
  logic [7:0] out_off_r;
  logic [7:0] out_len_r;

  logic       in_xfer;
  logic       out_xfer;
  logic [7:0] len_eff;
  logic [8:0] struct_end;
  logic [8:0] struct_start;
  logic       result_ok;

  // handshake
  assign in_stall = out_valid_r & out_stall & in_last_byte;
  assign in_xfer  = in_valid & ~in_stall;
  assign out_xfer = out_valid_r & ~out_stall;

  // frame length clamped to the supported maximum
  assign len_eff = ({1'b0, in_adv_len} > MAX_ADV_LEN) ? MAX_ADV_LEN[7:0] : in_adv_len;

  // end of a structure whose length byte is the current byte
  assign struct_end   = {1'b0, pos_r} + 9'd1 + {1'b0, in_adv_byte};
  // start of the structure being checked
  assign struct_start = next_start_r - 9'd1 - {1'b0, struct_len_r};

  // walk one byte
  always_comb begin
    stage_nxt      = stage_r;
    next_start_nxt = next_start_r;
    struct_len_nxt = struct_len_r;
    stopped_nxt    = stopped_r;
    found_nxt      = found_r;
    match_off_nxt  = match_off_r;
    match_len_nxt  = match_len_r;
    if (!stopped_r && (pos_r < len_eff)) begin
      case (stage_r)
        WAIT_LEN: begin
          if ({1'b0, pos_r} == next_start_r) begin
            if ((in_adv_byte == 8'd0) || (struct_end > {1'b0, len_eff})) begin
              stopped_nxt = 1'b1;
            end else begin
              struct_len_nxt = in_adv_byte;
              next_start_nxt = struct_end;
              stage_nxt      = CHK_TYPE;
            end
          end
        end
        CHK_TYPE: begin
          stage_nxt = ((in_adv_byte == AD_TYPE_SVC16) && (struct_len_r >= MIN_SVC_LEN))
                      ? CHK_UUID_LO : WAIT_LEN;
        end
        CHK_UUID_LO: begin
          stage_nxt = (in_adv_byte == UUID_LO) ? CHK_UUID_HI : WAIT_LEN;
        end
        CHK_UUID_HI: begin
          stage_nxt = (in_adv_byte == UUID_HI) ? CHK_APP : WAIT_LEN;
        end
        CHK_APP: begin
          stage_nxt = WAIT_LEN;
          if (in_adv_byte == ODID_APP_ID) begin
            found_nxt     = 1'b1;
            match_off_nxt = struct_start[7:0] + MSG_OFFSET;
            match_len_nxt = struct_len_r - MIN_SVC_LEN;
            stopped_nxt   = 1'b1;
          end
        end
        default: begin
          stage_nxt = WAIT_LEN;
        end
      endcase
    end
    // byte position saturates
    pos_nxt = (pos_r != 8'hFF) ? pos_r + 8'd1 : pos_r;
  end

  assign result_ok = found_nxt & (len_eff >= MIN_FRAME_LEN);

  // walk state, cleared after the last byte of each frame
  always_ff @(posedge clk) begin
    if (!rst_n || (in_xfer && in_last_byte)) begin
      stage_r      <= WAIT_LEN;
      pos_r        <= '0;
      next_start_r <= '0;
      struct_len_r <= '0;
      stopped_r    <= 1'b0;
      found_r      <= 1'b0;
      match_off_r  <= '0;
      match_len_r  <= '0;
    end else if (in_xfer) begin
      stage_r      <= stage_nxt;
      pos_r        <= pos_nxt;
      next_start_r <= next_start_nxt;
      struct_len_r <= struct_len_nxt;
      stopped_r    <= stopped_nxt;
      found_r      <= found_nxt;
      match_off_r  <= match_off_nxt;
      match_len_r  <= match_len_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_last_byte) begin
      out_found_r <= result_ok;
      out_off_r   <= result_ok ? match_off_nxt : 8'd0;
      out_len_r   <= result_ok ? match_len_nxt : 8'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_payload_offset = out_off_r;
  assign out_payload_length = out_len_r;

`ifndef ASSERT_OFF
  // a last byte never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_xfer && in_last_byte && out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  // a not-found result carries zero offset and length
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_off_r == 8'd0 && out_len_r == 8'd0))
    else $error("not-found result with non-zero fields");

  // a match always stops the walk
  a_found_stops: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> stopped_r)
    else $error("match recorded without stopping the walk");

  // a stopped walk sits waiting for a length byte
  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r != WAIT_LEN) |-> !stopped_r)
    else $error("walk stopped in the middle of a structure");
`endif

endmodule : ble_astm_service_data_finder
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds BLE advertisements byte by byte into the service-data finder, mixing
// well-formed frames that carry drone ID service data with near misses,
// truncated, overlong, short and noisy frames. A scoreboard walks the AD
// structures itself and checks the per-frame result on every output transfer.
// ----------------------------------------------------------------------------
module testbench
  import bsdf_pkg::*;
();

  localparam int QUIET_LIMIT = 2000;

  // walk position inside the identifier check
  typedef enum logic [2:0] {
    ST_LEN,
    ST_TYPE,
    ST_UUID_LO,
    ST_UUID_HI,
    ST_APP
  } walk_stage_t;

  typedef struct packed {
    logic       found;
    logic [7:0] offset;
    logic [7:0] length;
  } verdict_t;

  // --------------------------------------------------------------------------
  // scoreboard: walks each accepted byte and queues the frame verdicts
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    verdict_t    verdict_q[$];
    int unsigned mismatches;
    logic [7:0]  pos;
    logic [8:0]  next_start;
    logic [7:0]  slen;
    logic [7:0]  sstart;
    walk_stage_t stage;
    logic        stopped;
    logic        hit;
    logic [7:0]  hit_offset;
    logic [7:0]  hit_length;

    function new();
      mismatches = 0;
      clear_walk();
    endfunction

    function void clear_walk();
      pos        = '0;
      next_start = '0;
      slen       = '0;
      sstart     = '0;
      stage      = ST_LEN;
      stopped    = 1'b0;
      hit        = 1'b0;
      hit_offset = '0;
      hit_length = '0;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // one accepted input transfer
    function void note_byte(logic [7:0] b, logic [7:0] len, logic last);
      verdict_t v;
      if (!stopped && pos < len) begin
        case (stage)
          ST_LEN: begin
            if ({1'b0, pos} == next_start) begin
              if (b == 8'd0 || int'(pos) + 1 + int'(b) > int'(len)) begin
                stopped = 1'b1;
              end else begin
                slen       = b;
                sstart     = pos;
                next_start = {1'b0, pos} + 9'd1 + {1'b0, b};
                stage      = ST_TYPE;
              end
            end
          end
          ST_TYPE: begin
            stage = (b == AD_TYPE_SVC16 && slen >= MIN_SVC_LEN) ? ST_UUID_LO : ST_LEN;
          end
          ST_UUID_LO: stage = (b == UUID_LO) ? ST_UUID_HI : ST_LEN;
          ST_UUID_HI: stage = (b == UUID_HI) ? ST_APP : ST_LEN;
          default: begin
            stage = ST_LEN;
            if (b == ODID_APP_ID) begin
              hit        = 1'b1;
              hit_offset = sstart + MSG_OFFSET;
              hit_length = slen - MIN_SVC_LEN;
              stopped    = 1'b1;
            end
          end
        endcase
      end
      if (pos != 8'hFF) pos = pos + 8'd1;
      if (last) begin
        v.found  = hit && (len >= MIN_FRAME_LEN);
        v.offset = v.found ? hit_offset : 8'd0;
        v.length = v.found ? hit_length : 8'd0;
        verdict_q.push_back(v);
        clear_walk();
      end
    endfunction

    task report(string what);
      if (mismatches < 50) $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // one accepted output transfer
    task check_result(logic found, logic [7:0] offset, logic [7:0] length);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        report($sformatf("unexpected result found=%0b offset=%0d length=%0d",
                         found, offset, length));
        return;
      end
      want = verdict_q.pop_front();
      if (found !== want.found)
        report($sformatf("found %0b, expected %0b", found, want.found));
      if (offset !== want.offset)
        report($sformatf("payload_offset %0d, expected %0d", offset, want.offset));
      if (length !== want.length)
        report($sformatf("payload_length %0d, expected %0d", length, want.length));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_adv_byte  = '0;
  logic [7:0] in_adv_len   = '0;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic       out_found;
  logic [7:0] out_payload_offset;
  logic [7:0] out_payload_length;

  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 77;
  int unsigned bytes_sent    = 0;
  int unsigned quiet_cycles  = 0;
  logic [7:0]  adv_q[$];

  frame_scoreboard sb = new();

  always #4 clk = ~clk;

  ble_astm_service_data_finder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_adv_byte        (in_adv_byte),
    .in_adv_len         (in_adv_len),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_found          (out_found),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // transfer monitor: older result is checked before the new byte is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(out_found, out_payload_offset, out_payload_length);
      if (in_valid && !in_stall)
        sb.note_byte(in_adv_byte, in_adv_len, in_last_byte);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic [7:0] len, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_adv_byte  <= b;
    in_adv_len   <= len;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] clamp_len(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // send the whole of adv_q; jitter wobbles the length byte by byte
  task automatic send_adv(input int len_base, input bit mark_last, input bit jitter);
    int l;
    for (int i = 0; i < adv_q.size(); i++) begin
      l = jitter ? len_base + $urandom_range(4) - 2 : len_base;
      send_byte(adv_q[i], clamp_len(l), mark_last && (i == adv_q.size() - 1));
    end
  endtask

  // --------------------------------------------------------------------------
  // frame builders
  // --------------------------------------------------------------------------
  function automatic void add_filler();
    int n;
    n = $urandom_range(1, 6);
    adv_q.push_back(n[7:0]);
    adv_q.push_back(($urandom_range(9) == 0) ? AD_TYPE_SVC16 : 8'($urandom));
    repeat (n - 1) adv_q.push_back(8'($urandom));
  endfunction

  // service data with the identifier, optionally with one header byte spoilt
  function automatic void add_svc(bit spoil);
    int n;
    int base;
    int k;
    n    = ($urandom_range(9) == 0) ? 4 : $urandom_range(5, 12);
    base = adv_q.size();
    adv_q.push_back(n[7:0]);
    adv_q.push_back(AD_TYPE_SVC16);
    adv_q.push_back(UUID_LO);
    adv_q.push_back(UUID_HI);
    adv_q.push_back(ODID_APP_ID);
    repeat (n - 4) adv_q.push_back(8'($urandom));
    if (spoil) begin
      k = $urandom_range(1, 4);
      adv_q[base + k] = adv_q[base + k] ^ 8'($urandom_range(1, 255));
    end
  endfunction

  function automatic void build_adv();
    adv_q.delete();
    repeat ($urandom_range(2)) add_filler();
    if ($urandom_range(99) < 75) add_svc($urandom_range(99) < 30);
    repeat ($urandom_range(2)) add_filler();
    // zero padding up to the legacy advertisement size
    if ($urandom_range(99) < 20)
      while (adv_q.size() < 31) adv_q.push_back(8'd0);
  endfunction

  // --------------------------------------------------------------------------
  // random frames
  // --------------------------------------------------------------------------
  task automatic run_random(input int unsigned n);
    int unsigned goal;
    int          kind;
    int          sz;
    int          want;
    goal = bytes_sent + n;
    while (bytes_sent < goal) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        build_adv();
        send_adv(adv_q.size(), 1, 0);
      end else if (kind < 65) begin
        // frame may end before its announced length
        build_adv();
        sz    = adv_q.size();
        adv_q = adv_q[0:$urandom_range(sz - 1)];
        send_adv(sz + $urandom_range(3), 1, 0);
      end else if (kind < 72) begin
        build_adv();
        send_adv(adv_q.size(), 1, 1);
      end else if (kind < 78) begin
        // short frame, often a truncated match
        adv_q = '{8'd5, AD_TYPE_SVC16, UUID_LO, UUID_HI, ODID_APP_ID, 8'd0};
        adv_q = adv_q[0:$urandom_range(5)];
        send_adv($urandom_range(7), 1, 0);
      end else if (kind < 84) begin
        // announced length shorter than the bytes sent
        build_adv();
        send_adv($urandom_range(adv_q.size() - 1), 1, 0);
      end else if (kind < 90) begin
        // no last mark: the next frame runs on into this one
        build_adv();
        send_adv(adv_q.size() + $urandom_range(20), 0, 0);
      end else if (kind < 96) begin
        adv_q.delete();
        repeat ($urandom_range(1, 20)) adv_q.push_back(8'($urandom));
        send_adv($urandom_range(255), 1, 0);
      end else begin
        // long frame, sometimes past the position counter's top
        adv_q.delete();
        want = $urandom_range(120, 300);
        while (adv_q.size() < want) begin
          if ($urandom_range(99) < 15) add_svc($urandom_range(99) < 50);
          else add_filler();
        end
        send_adv(adv_q.size(), 1, 0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // smallest match
    adv_q = '{8'd5, AD_TYPE_SVC16, UUID_LO, UUID_HI, ODID_APP_ID, 8'd0};
    send_adv(6, 1, 0);
    // match after a flags structure
    adv_q = '{8'd2, 8'h01, 8'h06, 8'd7, AD_TYPE_SVC16, UUID_LO, UUID_HI, ODID_APP_ID,
              8'hAA, 8'hBB, 8'hCC};
    send_adv(11, 1, 0);
    // service data too short to count
    adv_q = '{8'd4, AD_TYPE_SVC16, UUID_LO, UUID_HI, ODID_APP_ID, 8'd2, 8'h01, 8'h06};
    send_adv(8, 1, 0);
    // each header byte wrong in turn
    adv_q = '{8'd5, 8'h17, UUID_LO, UUID_HI, ODID_APP_ID, 8'd0,
              8'd5, AD_TYPE_SVC16, 8'hFB, UUID_HI, ODID_APP_ID, 8'd0,
              8'd5, AD_TYPE_SVC16, UUID_LO, 8'hFE, ODID_APP_ID, 8'd0,
              8'd5, AD_TYPE_SVC16, UUID_LO, UUID_HI, 8'h0C, 8'd0};
    send_adv(24, 1, 0);
    // zero length byte ends the walk
    adv_q = '{8'd0, 8'd5, AD_TYPE_SVC16, UUID_LO, UUID_HI, ODID_APP_ID, 8'd0};
    send_adv(7, 1, 0);
    // structure overruns the frame
    adv_q = '{8'd9, AD_TYPE_SVC16, UUID_LO, UUID_HI, ODID_APP_ID, 8'd1, 8'd2};
    send_adv(7, 1, 0);
    // match seen, but the length on the last byte is short
    adv_q = '{8'd5, AD_TYPE_SVC16, UUID_LO, UUID_HI, ODID_APP_ID};
    send_adv(6, 0, 0);
    send_byte(8'd0, 8'd5, 1'b1);
    // early last byte after and before the identifier is complete
    adv_q = '{8'd8, AD_TYPE_SVC16, UUID_LO, UUID_HI, ODID_APP_ID};
    send_adv(9, 1, 0);
    adv_q = '{8'd8, AD_TYPE_SVC16, UUID_LO, UUID_HI};
    send_adv(9, 1, 0);
    // match lies past the announced length
    adv_q = '{8'd2, 8'h01, 8'h06, 8'd5, AD_TYPE_SVC16, UUID_LO, UUID_HI, ODID_APP_ID,
              8'd0};
    send_adv(3, 1, 0);
    // missing last byte joins two frames
    adv_q = '{8'd2, 8'h01, 8'h06};
    send_adv(9, 0, 0);
    adv_q = '{8'd5, AD_TYPE_SVC16, UUID_LO, UUID_HI, ODID_APP_ID, 8'd0};
    send_adv(9, 1, 0);
    // only the first of two matches counts
    adv_q = '{8'd5, AD_TYPE_SVC16, UUID_LO, UUID_HI, ODID_APP_ID, 8'h11,
              8'd6, AD_TYPE_SVC16, UUID_LO, UUID_HI, ODID_APP_ID, 8'h22, 8'h33};
    send_adv(13, 1, 0);
    // field extremes
    send_byte(8'hFF, 8'hFF, 1'b1);
    send_byte(8'h00, 8'h00, 1'b1);

    // random traffic in three back-pressure settings
    run_random(550);
    send_idle_pct = 77;
    recv_idle_pct = 12;
    run_random(550);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(550);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
